// ===== hw/rtl/darr_pkg.sv =====
// ----------------------------------------------------------------------------
// darr_pkg
// Types, constants and helpers shared by the A-record responder modules.
// ----------------------------------------------------------------------------
package darr_pkg;

    localparam logic [1:0] CMD_QUERY  = 2'd0;
    localparam logic [1:0] CMD_NAME   = 2'd1;
    localparam logic [1:0] CMD_COMMIT = 2'd2;

    localparam int HEADER_BYTES = 12;
    localparam int ANSWER_BYTES = 16;
    localparam int MAX_HOPS     = 8;
    localparam int OFFS_W       = 14;

    localparam logic [7:0] PTR_MASK  = 8'hc0;
    localparam logic [7:0] PTR_LOW   = 8'h3f;
    localparam logic [7:0] QR_BIT    = 8'h80;
    localparam logic [7:0] LABEL_DOT = 8'h2e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COMMIT,
        ST_STATUS,
        ST_WLAB,
        ST_WLABD,
        ST_WPTR,
        ST_WCOPY,
        ST_WCPW,
        ST_MENT,
        ST_MCHK,
        ST_MRD,
        ST_MCMP,
        ST_ERD,
        ST_EACC,
        ST_EOUT
    } state_t;

    typedef enum logic [1:0] {
        ZS_IDLE,
        ZS_CPRD,
        ZS_CPWR,
        ZS_DONE
    } zstate_t;

    typedef struct packed {
        logic done;
        logic fail;
    } zstat_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        fold = (c >= 8'h41 && c <= 8'h5a) ? (c + 8'h20) : c;
    endfunction

    // bytes of the fixed A answer; the address bytes come from the entry
    function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                               input logic [31:0] addr);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            4'd0:    b = 8'hc0;
            4'd1:    b = 8'h0c;
            4'd3:    b = 8'h01;
            4'd5:    b = 8'h01;
            4'd9:    b = 8'h08;
            4'd11:   b = 8'h04;
            4'd12:   b = addr[31:24];
            4'd13:   b = addr[23:16];
            4'd14:   b = addr[15:8];
            4'd15:   b = addr[7:0];
            default: b = 8'h00;
        endcase
        answer_byte = b;
    endfunction

endpackage

// ===== hw/rtl/darr_zone.sv =====
// ----------------------------------------------------------------------------
// darr_zone
// Zone table: staged name buffer, name memory, per-entry length/address and
// used flags, with the commit sequencer that copies a staged name into a slot.
// ----------------------------------------------------------------------------
module darr_zone #(
    parameter int ZONE_ENTRIES = 8,
    parameter int NAME_BYTES   = 80,
    parameter int ES           = 3,
    parameter int NIW          = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  stage_we,
    input  logic [7:0]            stage_byte,
    input  logic                  commit,
    input  logic [31:0]           commit_addr,
    input  logic [ES-1:0]         rd_entry,
    input  logic [NIW-1:0]        rd_index,
    output logic [7:0]            rd_byte,
    output logic                  ent_used,
    output logic [NIW-1:0]        ent_len,
    output logic [31:0]           ent_addr,
    output darr_pkg::zstat_t      zst
);
    import darr_pkg::*;

    localparam int ZD = ZONE_ENTRIES * NAME_BYTES;
    localparam int ZW = (ZD > 1) ? $clog2(ZD) : 1;

    logic [7:0]     stage_mem [NAME_BYTES];
    logic [7:0]     name_mem  [ZD];
    logic [NIW-1:0] len_mem   [ZONE_ENTRIES];
    logic [31:0]    addr_mem  [ZONE_ENTRIES];

    logic [ZONE_ENTRIES-1:0] used_reg, used_next;
    logic [NIW-1:0]          slen_reg, slen_next;
    logic [NIW-1:0]          k_reg, k_next;
    logic [ES-1:0]           slot_reg, slot_next;
    logic [31:0]             caddr_reg, caddr_next;
    logic                    fail_reg, fail_next;
    zstate_t                 zs_reg, zs_next;

    logic [7:0]     stage_rdata_reg;
    logic [7:0]     rd_byte_reg;
    logic [NIW-1:0] ent_len_reg;
    logic [31:0]    ent_addr_reg;
    logic           ent_used_reg;

    logic          free_found;
    logic [ES-1:0] free_slot;
    logic          zwe;
    logic          ent_we;

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = ZONE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = ES'(i);
            end
        end
    end

    always_comb
    begin
        zs_next    = zs_reg;
        used_next  = used_reg;
        slen_next  = slen_reg;
        k_next     = k_reg;
        slot_next  = slot_reg;
        caddr_next = caddr_reg;
        fail_next  = fail_reg;
        zwe        = 1'b0;
        ent_we     = 1'b0;
        if (stage_we && stage_byte != 8'h00 &&
            ({1'b0, slen_reg} + 1'b1) < (NIW + 1)'(NAME_BYTES))
        begin
            slen_next = slen_reg + 1'b1;
        end
        unique case (zs_reg)
            ZS_IDLE:
            begin
                if (commit)
                begin
                    caddr_next = commit_addr;
                    slot_next  = free_slot;
                    k_next     = '0;
                    if (slen_reg != '0 && free_found)
                    begin
                        fail_next = 1'b0;
                        zs_next   = ZS_CPRD;
                    end
                    else
                    begin
                        fail_next = 1'b1;
                        zs_next   = ZS_DONE;
                    end
                end
            end
            ZS_CPRD:
            begin
                if (k_reg == slen_reg)
                begin
                    ent_we              = 1'b1;
                    used_next[slot_reg] = 1'b1;
                    zs_next             = ZS_DONE;
                end
                else
                begin
                    zs_next = ZS_CPWR;
                end
            end
            ZS_CPWR:
            begin
                zwe     = 1'b1;
                k_next  = k_reg + 1'b1;
                zs_next = ZS_CPRD;
            end
            ZS_DONE:
            begin
                slen_next = '0;
                zs_next   = ZS_IDLE;
            end
            default: zs_next = ZS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zs_reg   <= ZS_IDLE;
            used_reg <= '0;
            slen_reg <= '0;
        end
        else
        begin
            zs_reg   <= zs_next;
            used_reg <= used_next;
            slen_reg <= slen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        slot_reg  <= slot_next;
        caddr_reg <= caddr_next;
        fail_reg  <= fail_next;
    end

    // staged name buffer
    always_ff @(posedge clk)
    begin
        if (stage_we && stage_byte != 8'h00 &&
            ({1'b0, slen_reg} + 1'b1) < (NIW + 1)'(NAME_BYTES))
        begin
            stage_mem[slen_reg] <= stage_byte;
        end
        stage_rdata_reg <= stage_mem[k_reg];
    end

    // zone name memory: commit writes, lookup reads
    always_ff @(posedge clk)
    begin
        if (zwe)
        begin
            name_mem[ZW'(slot_reg * NAME_BYTES) + ZW'(k_reg)] <= stage_rdata_reg;
        end
        rd_byte_reg <= name_mem[ZW'(rd_entry * NAME_BYTES) + ZW'(rd_index)];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            len_mem[slot_reg]  <= slen_reg;
            addr_mem[slot_reg] <= caddr_reg;
        end
        ent_len_reg  <= len_mem[rd_entry];
        ent_addr_reg <= addr_mem[rd_entry];
        ent_used_reg <= used_reg[rd_entry];
    end

    assign rd_byte  = rd_byte_reg;
    assign ent_len  = ent_len_reg;
    assign ent_addr = ent_addr_reg;
    assign ent_used = ent_used_reg;
    assign zst.done = (zs_reg == ZS_DONE);
    assign zst.fail = fail_reg;

endmodule

// ===== hw/rtl/dns_a_record_responder_core.sv =====
// ----------------------------------------------------------------------------
// dns_a_record_responder_core
// Answers DNS A queries from a small zone table, replying as 64-bit words.
// ----------------------------------------------------------------------------
// Requests are taken only while the block is idle. A query byte or zone
// name byte is stored as it is taken. A commit copies the staged name
// into a free table slot byte by byte and then returns an add status.
// At the last query byte, if listening and the length is in range, the
// block walks the question name through the packet memory, following
// labels and pointers, compares it against candidate entries of equal
// length and then streams the reply out as 64-bit words; the single read
// port of each memory paces these steps. A full output register stalls
// the reply until it is taken.
module dns_a_record_responder_core #(
    parameter int ZONE_ENTRIES  = 8,
    parameter int NAME_BYTES    = 80,
    parameter int MESSAGE_BYTES = 512
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // data_byte[7:0], zone_address[39:8], client_address[71:40],
    // client_port[87:72]
    input  logic [87:0]  s_tdata,
    // last_byte
    input  logic         s_tlast,
    // cmd
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // response_word[63:0], byte_count[67:64], dest_address[99:68],
    // dest_port[115:100], add_status[116], zero[119:117]
    output logic [119:0] m_tdata,
    // last_word
    output logic         m_tlast,
    // result_kind
    output logic         m_tuser
);
    import darr_pkg::*;

    localparam int PIW = $clog2(MESSAGE_BYTES);
    localparam int PLW = $clog2(MESSAGE_BYTES + 1);
    localparam int NIW = $clog2(NAME_BYTES);
    localparam int ES  = (ZONE_ENTRIES > 1) ? $clog2(ZONE_ENTRIES) : 1;
    localparam int EW  = $clog2(ZONE_ENTRIES + 1);
    localparam int OW  = (OFFS_W > PLW) ? OFFS_W : PLW;

    logic [7:0] pkt_mem  [MESSAGE_BYTES];
    logic [7:0] name_mem [NAME_BYTES];

    state_t         state_reg, state_next;
    logic           listen_reg;
    logic [PLW-1:0] len_reg, len_next;
    logic [PLW-1:0] qlen_reg, qlen_next;
    logic [31:0]    dst_reg, dst_next;
    logic [15:0]    port_reg, port_next;
    logic [OW-1:0]  o_reg, o_next;
    logic [NIW-1:0] n_reg, n_next;
    logic [NIW-1:0] k_reg, k_next;
    logic [7:0]     lab_reg, lab_next;
    logic [7:0]     cnt_reg, cnt_next;
    logic [3:0]     hops_reg, hops_next;
    logic [EW-1:0]  e_reg, e_next;
    logic [PLW-1:0] p_reg, p_next;
    logic [3:0]     bc_reg, bc_next;
    logic [63:0]    word_reg, word_next;

    logic [PIW-1:0] pkt_raddr;
    logic [7:0]     pkt_rdata_reg;
    logic           pkt_we;
    logic           nm_we;
    logic [7:0]     nm_wdata;
    logic [7:0]     nm_rdata_reg;

    logic           out_valid_reg, out_valid_next;
    logic [119:0]   out_data_reg, out_data_next;
    logic           out_last_reg, out_last_next;
    logic           out_kind_reg, out_kind_next;
    logic           out_free;

    logic           accept;
    logic [1:0]     cmd;
    logic [7:0]     in_byte;
    logic           stage_we;
    logic           commit;
    logic [7:0]     zrd_byte;
    logic           ent_used;
    logic [NIW-1:0] ent_len;
    logic [31:0]    ent_addr;
    zstat_t         zst;

    logic [PLW-1:0] total;
    logic [PLW-1:0] p_inc;
    logic [3:0]     bc_inc;
    logic [4:0]     aidx;
    logic [7:0]     ebyte;
    logic [OW:0]    o_inc;
    logic [OW+1:0]  o_end;
    logic [NIW+1:0] n_end;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cmd      = s_tuser;
    assign in_byte  = s_tdata[7:0];
    assign out_free = !out_valid_reg || m_tready;
    assign stage_we = accept && cmd == CMD_NAME;
    assign commit   = accept && cmd == CMD_COMMIT;

    assign total  = qlen_reg + PLW'(ANSWER_BYTES);
    assign p_inc  = p_reg + 1'b1;
    assign bc_inc = bc_reg + 1'b1;
    assign aidx   = 5'(p_reg - qlen_reg);
    assign o_inc  = {1'b0, o_reg} + 1'b1;
    assign o_end  = {1'b0, o_inc} + (OW + 2)'(pkt_rdata_reg);
    assign n_end  = (NIW + 2)'(n_reg) + (NIW + 2)'(pkt_rdata_reg) + 1'b1;

    always_comb
    begin
        ebyte = answer_byte(aidx[3:0], ent_addr);
        if (p_reg < qlen_reg)
        begin
            ebyte = pkt_rdata_reg;
            case (p_reg)
                PLW'(2): ebyte = pkt_rdata_reg | QR_BIT;
                PLW'(3): ebyte = 8'h00;
                PLW'(6): ebyte = 8'h00;
                PLW'(7): ebyte = 8'h01;
                default: ebyte = pkt_rdata_reg;
            endcase
        end
    end

    darr_zone #(
        .ZONE_ENTRIES (ZONE_ENTRIES),
        .NAME_BYTES   (NAME_BYTES),
        .ES           (ES),
        .NIW          (NIW)
    ) u_zone (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_we    (stage_we),
        .stage_byte  (in_byte),
        .commit      (commit),
        .commit_addr (s_tdata[39:8]),
        .rd_entry    (e_reg[ES-1:0]),
        .rd_index    (k_reg),
        .rd_byte     (zrd_byte),
        .ent_used    (ent_used),
        .ent_len     (ent_len),
        .ent_addr    (ent_addr),
        .zst         (zst)
    );

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        qlen_next      = qlen_reg;
        dst_next       = dst_reg;
        port_next      = port_reg;
        o_next         = o_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        lab_next       = lab_reg;
        cnt_next       = cnt_reg;
        hops_next      = hops_reg;
        e_next         = e_reg;
        p_next         = p_reg;
        bc_next        = bc_reg;
        word_next      = word_reg;
        pkt_raddr      = o_reg[PIW-1:0];
        pkt_we         = 1'b0;
        nm_we          = 1'b0;
        nm_wdata       = pkt_rdata_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_kind_next  = out_kind_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd == CMD_QUERY)
                begin
                    pkt_we = (len_reg < PLW'(MESSAGE_BYTES));
                    if (pkt_we)
                    begin
                        len_next = len_reg + 1'b1;
                    end
                    if (s_tlast)
                    begin
                        qlen_next = len_next;
                        len_next  = '0;
                        dst_next  = s_tdata[71:40];
                        port_next = s_tdata[87:72];
                        o_next    = OW'(HEADER_BYTES);
                        n_next    = '0;
                        hops_next = '0;
                        if (listen_reg && qlen_next >= PLW'(HEADER_BYTES) &&
                            qlen_next <= PLW'(MESSAGE_BYTES - ANSWER_BYTES))
                        begin
                            state_next = ST_WLAB;
                        end
                    end
                end
                else if (commit)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                // the output register may still hold a waiting result
                if (zst.done)
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = 1'b1;
                    out_last_next  = 1'b0;
                    out_data_next  = '0;
                    out_data_next[116] = zst.fail;
                    state_next     = ST_IDLE;
                end
            end
            ST_WLAB:
            begin
                if (o_reg >= OW'(qlen_reg))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WLABD;
                end
            end
            ST_WLABD:
            begin
                lab_next = pkt_rdata_reg;
                if ((pkt_rdata_reg & PTR_MASK) == PTR_MASK)
                begin
                    pkt_raddr = o_inc[PIW-1:0];
                    if (o_inc >= (OW + 1)'(qlen_reg) || hops_reg > 4'(MAX_HOPS))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WPTR;
                    end
                end
                else
                begin
                    o_next = o_inc[OW-1:0];
                    if (pkt_rdata_reg == 8'h00)
                    begin
                        e_next     = '0;
                        state_next = ST_MENT;
                    end
                    else if (o_end > (OW + 2)'(qlen_reg) ||
                             n_end >= (NIW + 2)'(NAME_BYTES))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (n_reg != '0)
                        begin
                            nm_we    = 1'b1;
                            nm_wdata = LABEL_DOT;
                            n_next   = n_reg + 1'b1;
                        end
                        cnt_next   = pkt_rdata_reg;
                        state_next = ST_WCOPY;
                    end
                end
            end
            ST_WPTR:
            begin
                o_next     = OW'({lab_reg[5:0] & PTR_LOW[5:0], pkt_rdata_reg});
                hops_next  = hops_reg + 1'b1;
                state_next = ST_WLAB;
            end
            ST_WCOPY:
            begin
                if (cnt_reg == 8'h00)
                begin
                    state_next = ST_WLAB;
                end
                else
                begin
                    o_next     = o_inc[OW-1:0];
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_WCPW;
                end
            end
            ST_WCPW:
            begin
                nm_we      = 1'b1;
                n_next     = n_reg + 1'b1;
                state_next = ST_WCOPY;
            end
            ST_MENT:
            begin
                if (e_reg == EW'(ZONE_ENTRIES))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MCHK;
                end
            end
            ST_MCHK:
            begin
                k_next = '0;
                if (ent_used && ent_len == n_reg)
                begin
                    state_next = ST_MRD;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_MENT;
                end
            end
            ST_MRD:
            begin
                if (k_reg == n_reg)
                begin
                    p_next     = '0;
                    bc_next    = '0;
                    word_next  = '0;
                    state_next = ST_ERD;
                end
                else
                begin
                    state_next = ST_MCMP;
                end
            end
            ST_MCMP:
            begin
                if (fold(zrd_byte) == fold(nm_rdata_reg))
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_MRD;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_MENT;
                end
            end
            ST_ERD:
            begin
                pkt_raddr  = p_reg[PIW-1:0];
                state_next = ST_EACC;
            end
            ST_EACC:
            begin
                word_next[8 * (7 - bc_reg[2:0]) +: 8] = ebyte;
                bc_next = bc_inc;
                p_next  = p_inc;
                if (bc_inc == 4'd8 || p_inc == total)
                begin
                    state_next = ST_EOUT;
                end
                else
                begin
                    state_next = ST_ERD;
                end
            end
            ST_EOUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = 1'b0;
                    out_last_next  = (p_reg == total);
                    out_data_next  = {4'h0, port_reg, dst_reg, bc_reg, word_reg};
                    bc_next        = '0;
                    word_next      = '0;
                    state_next     = (p_reg == total) ? ST_IDLE : ST_ERD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            listen_reg    <= 1'b0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                listen_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        qlen_reg     <= qlen_next;
        dst_reg      <= dst_next;
        port_reg     <= port_next;
        o_reg        <= o_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        lab_reg      <= lab_next;
        cnt_reg      <= cnt_next;
        hops_reg     <= hops_next;
        e_reg        <= e_next;
        p_reg        <= p_next;
        bc_reg       <= bc_next;
        word_reg     <= word_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_kind_reg <= out_kind_next;
    end

    // packet memory
    always_ff @(posedge clk)
    begin
        if (pkt_we)
        begin
            pkt_mem[len_reg[PIW-1:0]] <= in_byte;
        end
        pkt_rdata_reg <= pkt_mem[pkt_raddr];
    end

    // decoded question name
    always_ff @(posedge clk)
    begin
        if (nm_we)
        begin
            name_mem[n_reg] <= nm_wdata;
        end
        nm_rdata_reg <= name_mem[k_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[115:0] == '0 && !m_tlast))
        else $error("status result carries response fields");

    a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= 4'd8))
        else $error("response word byte count out of range");

    a_hop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WPTR) |=> (hops_reg <= 4'(MAX_HOPS + 1)))
        else $error("pointer walk exceeded hop limit");

    a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
        zst.done |-> (state_reg == ST_COMMIT))
        else $error("zone commit finished outside commit state");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams zone loads and DNS query packets into the A-record responder,
// predicts every reply word and add status, and checks them in order while
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import darr_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int ZONES     = 8;
    localparam int NAME_CAP  = 80;
    localparam int MSG_MAX   = 512;
    localparam int SETTLE    = 3000;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  data;
        logic        last;
        logic [31:0] zaddr;
        logic [31:0] caddr;
        logic [15:0] cport;
    } request_t;

    typedef struct {
        logic        kind;
        logic [63:0] word;
        logic [3:0]  count;
        logic        last;
        logic [31:0] daddr;
        logic [15:0] dport;
        logic        status;
    } result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [87:0]  s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic [1:0]   s_tuser = 2'd0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;

    dns_a_record_responder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // responder state as the checker sees it
    logic [7:0]  pkt_mem [MSG_MAX];
    int          pkt_len = 0;
    logic [7:0]  zone_mem [ZONES][NAME_CAP];
    int          zone_len [ZONES];
    logic [31:0] zone_ip [ZONES];
    bit          zone_used [ZONES];
    logic [7:0]  staged [NAME_CAP];
    int          staged_len = 0;
    bit          listening = 1'b0;
    logic [7:0]  qname [NAME_CAP];
    int          qname_len;
    logic [7:0]  reply_buf [MSG_MAX];

    result_t     replies_due [$];
    request_t    send_q [$];
    request_t    cur_req;
    int          errors = 0;
    int          pushed = 0;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit decode_question();
        int  o;
        int  n;
        int  hops;
        int  lab;
        o = HEADER_BYTES;
        n = 0;
        hops = 0;
        while (o < pkt_len) begin
            lab = int'(pkt_mem[o]);
            if ((lab & 8'hc0) == 8'hc0) begin
                if (o + 1 >= pkt_len || hops > 8)
                    return 1'b0;
                hops++;
                o = ((lab & 8'h3f) << 8) | int'(pkt_mem[o + 1]);
            end
            else begin
                o++;
                if (lab == 0) begin
                    qname_len = n;
                    return 1'b1;
                end
                if (o + lab > pkt_len || n + lab + 1 >= NAME_CAP)
                    return 1'b0;
                if (n != 0) begin
                    qname[n] = ".";
                    n++;
                end
                for (int k = 0; k < lab; k++)
                    qname[n + k] = pkt_mem[o + k];
                n += lab;
                o += lab;
            end
        end
        return 1'b0;
    endfunction

    function automatic int find_zone();
        bit same;
        for (int i = 0; i < ZONES; i++) begin
            if (zone_used[i] && zone_len[i] == qname_len) begin
                same = 1'b1;
                for (int k = 0; k < qname_len; k++)
                    if (lower_ascii(zone_mem[i][k]) != lower_ascii(qname[k]))
                        same = 1'b0;
                if (same)
                    return i;
            end
        end
        return ZONES;
    endfunction

    task automatic build_reply(input logic [31:0] dst, input logic [15:0] port);
        int          zi;
        int          n;
        int          cnt;
        logic [31:0] a;
        result_t     r;
        if (pkt_len < HEADER_BYTES || !listening)
            return;
        if (!decode_question())
            return;
        zi = find_zone();
        if (zi >= ZONES || pkt_len > MSG_MAX - ANSWER_BYTES)
            return;
        for (int i = 0; i < pkt_len; i++)
            reply_buf[i] = pkt_mem[i];
        reply_buf[2] = reply_buf[2] | 8'h80;
        reply_buf[3] = 8'h00;
        reply_buf[6] = 8'h00;
        reply_buf[7] = 8'h01;
        a = zone_ip[zi];
        n = pkt_len;
        reply_buf[n] = 8'hc0; reply_buf[n+1] = 8'h0c;
        reply_buf[n+2] = 8'h00; reply_buf[n+3] = 8'h01;
        reply_buf[n+4] = 8'h00; reply_buf[n+5] = 8'h01;
        reply_buf[n+6] = 8'h00; reply_buf[n+7] = 8'h00;
        reply_buf[n+8] = 8'h00; reply_buf[n+9] = 8'h08;
        reply_buf[n+10] = 8'h00; reply_buf[n+11] = 8'h04;
        reply_buf[n+12] = a[31:24]; reply_buf[n+13] = a[23:16];
        reply_buf[n+14] = a[15:8]; reply_buf[n+15] = a[7:0];
        n += ANSWER_BYTES;
        for (int pos = 0; pos < n; pos += 8) begin
            cnt = (n - pos < 8) ? n - pos : 8;
            r.kind = 1'b0;
            r.word = '0;
            for (int k = 0; k < 8; k++)
                r.word = {r.word[55:0], (k < cnt) ? reply_buf[pos + k] : 8'h00};
            r.count = 4'(cnt);
            r.last = (pos + cnt >= n);
            r.daddr = dst;
            r.dport = port;
            r.status = 1'b0;
            replies_due.push_back(r);
        end
    endtask

    task automatic apply_request(input request_t q);
        result_t r;
        case (q.cmd)
            CMD_QUERY:
            begin
                if (pkt_len < MSG_MAX)
                    pkt_mem[pkt_len++] = q.data;
                if (q.last) begin
                    build_reply(q.caddr, q.cport);
                    pkt_len = 0;
                end
            end
            CMD_NAME:
            begin
                if (q.data != 0 && staged_len + 1 < NAME_CAP)
                    staged[staged_len++] = q.data;
            end
            CMD_COMMIT:
            begin
                r = '{kind: 1'b1, word: '0, count: '0, last: 1'b0, daddr: '0,
                      dport: '0, status: 1'b1};
                if (staged_len != 0) begin
                    for (int i = 0; i < ZONES; i++) begin
                        if (!zone_used[i] && r.status) begin
                            for (int k = 0; k < staged_len; k++)
                                zone_mem[i][k] = staged[k];
                            zone_len[i] = staged_len;
                            zone_ip[i] = q.zaddr;
                            zone_used[i] = 1'b1;
                            r.status = 1'b0;
                        end
                    end
                end
                staged_len = 0;
                replies_due.push_back(r);
            end
            default: ;
        endcase
    endtask

    function automatic int draw_wait(inout bit busy);
        if ($urandom_range(0, 15) == 0)
            busy = !busy;
        return busy ? $urandom_range(0, 16) : 0;
    endfunction

    // request driver
    int tx_gap = 0;
    bit tx_busy = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        request_t q;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end
        else begin
            if (s_tvalid && s_tready)
                apply_request(cur_req);
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (send_q.size() > 0) begin
                    q = send_q.pop_front();
                    cur_req <= q;
                    s_tvalid <= 1'b1;
                    s_tdata <= {q.cport, q.caddr, q.zaddr, q.data};
                    s_tlast <= q.last;
                    s_tuser <= q.cmd;
                    tx_gap = draw_wait(tx_busy);
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    logic hold_req = 1'b0;
    int   hold_left = 0;

    always @(posedge clk)
    begin
        if (hold_req)
            hold_left <= 4000;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t tb: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    // result monitor
    int rx_wait = 0;
    bit rx_busy = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : check_results
        result_t e;
        logic    ready_nxt;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[63:0], '0);
                end
                else begin
                    e = replies_due.pop_front();
                    if (m_tuser !== e.kind)
                        report_mismatch("result_kind", m_tuser, e.kind);
                    if (m_tdata[63:0] !== e.word)
                        report_mismatch("response_word", m_tdata[63:0], e.word);
                    if (m_tdata[67:64] !== e.count)
                        report_mismatch("byte_count", m_tdata[67:64], e.count);
                    if (m_tlast !== e.last)
                        report_mismatch("last_word", m_tlast, e.last);
                    if (m_tdata[99:68] !== e.daddr)
                        report_mismatch("dest_address", m_tdata[99:68], e.daddr);
                    if (m_tdata[115:100] !== e.dport)
                        report_mismatch("dest_port", m_tdata[115:100], e.dport);
                    if (m_tdata[116] !== e.status)
                        report_mismatch("add_status", m_tdata[116], e.status);
                end
                rx_wait = draw_wait(rx_busy);
            end
            ready_nxt = 1'b1;
            if (hold_left > 0) begin
                ready_nxt = 1'b0;
            end
            else if (rx_wait > 0) begin
                ready_nxt = 1'b0;
                rx_wait--;
            end
            m_tready <= ready_nxt;
        end
    end

    // stimulus
    logic [7:0] zone_txt [ZONES][NAME_CAP];
    int         zone_txt_len [ZONES];
    int         zone_known = 0;
    logic [7:0] name_tmp [NAME_CAP];
    int         name_tmp_len;
    logic [7:0] qbuf [$];

    task automatic push_req(input logic [1:0] cmd, input logic [7:0] data,
                            input logic last, input logic [31:0] caddr,
                            input logic [15:0] cport);
        request_t q;
        q.cmd = cmd;
        q.data = data;
        q.last = last;
        q.zaddr = $urandom;
        q.caddr = caddr;
        q.cport = cport;
        send_q.push_back(q);
        pushed++;
    endtask

    function automatic logic [7:0] name_char();
        int  k;
        k = $urandom_range(0, 62);
        if (k < 26)
            return 8'("a" + k);
        if (k < 52)
            return 8'("A" + k - 26);
        if (k < 62)
            return 8'("0" + k - 52);
        return "-";
    endfunction

    task automatic random_name();
        int labels;
        int ln;
        labels = $urandom_range(1, 3);
        name_tmp_len = 0;
        for (int l = 0; l < labels; l++) begin
            if (l != 0)
                name_tmp[name_tmp_len++] = ".";
            ln = $urandom_range(1, 12);
            for (int k = 0; k < ln; k++)
                name_tmp[name_tmp_len++] = name_char();
        end
    endtask

    // stage name_tmp, optionally with a stray zero byte, then commit
    task automatic add_zone(input bit keep, input bit stray_zero,
                            input logic [31:0] ip);
        request_t q;
        for (int k = 0; k < name_tmp_len; k++) begin
            if (stray_zero && k == 1)
                push_req(CMD_NAME, 8'h00, 1'b0, $urandom, 16'($urandom));
            push_req(CMD_NAME, name_tmp[k], 1'($urandom_range(0, 1)), $urandom,
                     16'($urandom));
        end
        push_req(CMD_COMMIT, 8'($urandom), 1'($urandom_range(0, 1)), $urandom,
                 16'($urandom));
        send_q[$].zaddr = ip;
        if (keep) begin
            for (int k = 0; k < name_tmp_len; k++)
                zone_txt[zone_known][k] = name_tmp[k];
            zone_txt_len[zone_known] = name_tmp_len;
            zone_known++;
        end
    endtask

    // header, a chain of pointers, the labels, the root, type and class
    task automatic build_query(input int zi, input int hops);
        int start;
        int off;
        logic [7:0] c;
        qbuf.delete();
        if (zi < 0) begin
            random_name();
        end
        else begin
            for (int k = 0; k < zone_txt_len[zi]; k++)
                name_tmp[k] = zone_txt[zi][k];
            name_tmp_len = zone_txt_len[zi];
        end
        for (int i = 0; i < HEADER_BYTES; i++)
            qbuf.push_back(8'($urandom));
        for (int h = 0; h < hops; h++) begin
            off = HEADER_BYTES + 2 * (h + 1);
            qbuf.push_back(8'hc0 | off[13:8]);
            qbuf.push_back(off[7:0]);
        end
        start = 0;
        for (int k = 0; k <= name_tmp_len; k++) begin
            if (k == name_tmp_len || name_tmp[k] == ".") begin
                qbuf.push_back(8'(k - start));
                for (int j = start; j < k; j++) begin
                    c = name_tmp[j];
                    if (lower_ascii(c) >= "a" && lower_ascii(c) <= "z" &&
                        $urandom_range(0, 1))
                        c = c ^ 8'h20;
                    qbuf.push_back(c);
                end
                start = k + 1;
            end
        end
        qbuf.push_back(8'h00);
        qbuf.push_back(8'h00); qbuf.push_back(8'h01);
        qbuf.push_back(8'h00); qbuf.push_back(8'h01);
    endtask

    task automatic pad_to(input int total);
        while (qbuf.size() < total)
            qbuf.push_back(8'($urandom));
    endtask

    task automatic send_packet();
        logic [31:0] ca;
        logic [15:0] cp;
        ca = $urandom;
        cp = 16'($urandom);
        for (int i = 0; i < qbuf.size(); i++)
            push_req(CMD_QUERY, qbuf[i], i == qbuf.size() - 1, ca, cp);
    endtask

    task automatic wait_idle();
        while (send_q.size() != 0 || s_tvalid || replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_listen(input logic v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        listening = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        int sel;
        int base;
        int iter;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zone table: empty commit, stray zero, 64-byte label, cut name, extremes
        name_tmp_len = 0;
        add_zone(1'b0, 1'b0, $urandom);
        random_name();
        add_zone(1'b1, 1'b1, $urandom);
        name_tmp_len = 64;
        for (int k = 0; k < 64; k++)
            name_tmp[k] = name_char();
        name_tmp[10] = "-";
        add_zone(1'b1, 1'b0, 32'hffff_ffff);
        name_tmp_len = 79;
        for (int k = 0; k < 79; k++)
            name_tmp[k] = name_char();
        for (int k = 0; k < 6; k++)
            push_req(CMD_NAME, name_char(), 1'b0, $urandom, 16'($urandom));
        add_zone(1'b0, 1'b0, $urandom);
        for (int z = 0; z < 5; z++) begin
            random_name();
            add_zone(1'b1, 1'b0, (z == 0) ? 32'h0 : $urandom);
        end
        random_name();
        add_zone(1'b0, 1'b0, $urandom);
        // not listening yet: dropped
        build_query(0, 0);
        send_packet();
        wait_idle();
        write_listen(1'b1);

        build_query(0, 0);
        send_packet();
        build_query(1, 0);
        send_packet();
        build_query(2, 9);
        send_packet();
        build_query(2, 10);
        send_packet();
        build_query(0, 0);
        qbuf[13] = 8'h00;
        send_packet();
        build_query(0, 0);
        qbuf[12] = 8'h80;
        send_packet();
        build_query(3, 0);
        qbuf[12] = 8'h3f;
        while (qbuf.size() > 20)
            void'(qbuf.pop_back());
        send_packet();
        build_query(-1, 0);
        send_packet();
        qbuf.delete();
        for (int i = 0; i < 13; i++)
            qbuf.push_back(8'hc0);
        send_packet();
        qbuf.delete();
        for (int i = 0; i < 5; i++)
            qbuf.push_back(8'($urandom));
        send_packet();
        build_query(4, 1);
        pad_to(MSG_MAX - ANSWER_BYTES);
        send_packet();
        build_query(4, 0);
        pad_to(MSG_MAX - ANSWER_BYTES + 1);
        send_packet();
        build_query(5, 0);
        pad_to(MSG_MAX + 8);
        send_packet();
        push_req(CMD_NONE, 8'hff, 1'b1, $urandom, 16'($urandom));
        push_req(CMD_NAME, 8'h41, 1'b1, $urandom, 16'($urandom));
        push_req(CMD_COMMIT, 8'h00, 1'b1, $urandom, 16'($urandom));
        wait_idle();

        base = pushed;
        iter = 0;
        while (pushed - base < 360) begin
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                build_query($urandom_range(0, zone_known - 1), $urandom_range(0, 3));
                pad_to(qbuf.size() + $urandom_range(0, 6));
                send_packet();
            end
            else if (sel < 73) begin
                build_query(-1, $urandom_range(0, 2));
                send_packet();
            end
            else if (sel < 81) begin
                build_query($urandom_range(0, zone_known - 1), $urandom_range(0, 2));
                while (qbuf.size() > 1 && $urandom_range(0, 3) != 0)
                    void'(qbuf.pop_back());
                send_packet();
            end
            else if (sel < 88) begin
                qbuf.delete();
                for (int i = $urandom_range(1, 24); i > 0; i--)
                    qbuf.push_back(8'($urandom));
                send_packet();
            end
            else if (sel < 94) begin
                build_query($urandom_range(0, zone_known - 1), $urandom_range(8, 10));
                send_packet();
            end
            else begin
                for (int i = $urandom_range(1, 4); i > 0; i--)
                    push_req(2'($urandom_range(CMD_NAME, CMD_NONE)), 8'($urandom),
                             1'($urandom_range(0, 1)), $urandom, 16'($urandom));
            end
            iter++;
            // hold the result side while requests keep coming
            if (iter == 4) begin
                @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            if (iter % 8 == 0)
                wait_idle();
        end
        wait_idle();

        write_listen(1'b0);
        build_query(0, 1);
        send_packet();
        wait_idle();
        write_listen(1'b1);
        build_query(1, 0);
        send_packet();
        wait_idle();

        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #12ms;
        $display("tb: done, errors");
        $finish;
    end

endmodule
